/* rtl/rwc_pkg.sv */
// Package for the register write coalescer.
// Holds item types, command codes, state encoding and controller/datapath links.
// No dependencies.
package rwc_pkg;

  localparam int BUFFER_DEPTH_DEF = 16;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_DELAY = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_WAIT    = 2'd1,
    CMD_FLUSH   = 2'd2,
    CMD_DISCARD = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] reg_addr;
    logic [7:0]  value;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] burst_base;
    logic [7:0]  payload;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DRAIN_PUSH,
    S_DRAIN_WAIT,
    S_DRAIN_END,
    S_STORE,
    S_DELAY,
    S_DELAY_OUT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic start_drain;
    logic drain_more;
    logic store;
    logic close;
    logic load_delay;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t pend_cmd;
    logic burst_open;
    logic contiguous;
    logic full_after_store;
    logic drain_done;
    logic delay_done;
  } dp_status_t;

endpackage

/* rtl/register_write_coalescer_top.sv */
// Top level of the register write coalescer.
// Instantiates rwc_ctrl and rwc_datapath; depends on rwc_pkg.
//
// Usage: single-byte register writes enter on the in_ channel (in_valid,
// in_stall, in_item). A push to the address right after the open burst is
// appended; any other push first sends the open burst out. A burst is also
// sent once it holds BUFFER_DEPTH bytes. Wait sends the burst and then one
// delay item, flush sends the burst only, and discard drops it unsent.
// Results leave on the out_ channel (out_valid, out_stall, out_item), one
// item per stored byte, oldest first, with last set on the final item that
// an input causes.
// Timing: one input item is handled at a time, taken only while the
// controller idles. The first result is registered from the decode state,
// or from the store state when a push fills the buffer, or from the delay
// state when a wait finds it empty. A burst streams at one byte per cycle
// from the byte store's registered read port while out_stall stays low.
// Reset (rst_n low, synchronous) closes the open burst and clears the output
// register; the byte store holds no reset. When the receiver raises out_stall
// the current item holds and the input side stalls until the drain finishes.
module register_write_coalescer_top #(
  parameter int BUFFER_DEPTH = rwc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rwc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rwc_pkg::out_item_t out_item
);
  import rwc_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t status;

  // Controller: decides what happens to each accepted item.
  rwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  // Datapath: burst bookkeeping, byte store and the output register.
  rwc_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctl       (ctl),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* rtl/rwc_ctrl.sv */
// Controller of the register write coalescer: sequences decode, drain, store and delay.
// Depends on rwc_pkg.
module rwc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rwc_pkg::dp_status_t status,
  output rwc_pkg::ctl_cmd_t   ctl
);
  import rwc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (status.pend_cmd)
          CMD_PUSH: begin
            if (status.burst_open && !status.contiguous) state_nxt = S_DRAIN_PUSH;
            else state_nxt = S_STORE;
          end
          CMD_WAIT: begin
            if (status.burst_open) state_nxt = S_DRAIN_WAIT;
            else state_nxt = S_DELAY;
          end
          CMD_FLUSH: begin
            if (status.burst_open) state_nxt = S_DRAIN_END;
            else state_nxt = S_IDLE;
          end
          CMD_DISCARD: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DRAIN_PUSH: begin
        if (status.drain_done) state_nxt = S_STORE;
      end
      S_DRAIN_WAIT: begin
        if (status.drain_done) state_nxt = S_DELAY;
      end
      S_DRAIN_END: begin
        if (status.drain_done) state_nxt = S_IDLE;
      end
      S_STORE: begin
        if (status.full_after_store) state_nxt = S_DRAIN_END;
        else state_nxt = S_IDLE;
      end
      S_DELAY: begin
        state_nxt = S_DELAY_OUT;
      end
      S_DELAY_OUT: begin
        if (status.delay_done) state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall     = 1'b0;
        ctl.latch_in = in_valid;
      end
      S_DECODE: begin
        unique case (status.pend_cmd)
          CMD_PUSH: begin
            ctl.start_drain = status.burst_open && !status.contiguous;
          end
          CMD_WAIT: begin
            ctl.start_drain = status.burst_open;
            ctl.drain_more  = 1'b1;
          end
          CMD_FLUSH: begin
            ctl.start_drain = status.burst_open;
          end
          CMD_DISCARD: begin
            ctl.close = 1'b1;
          end
        endcase
      end
      S_STORE: begin
        ctl.store       = 1'b1;
        ctl.start_drain = status.full_after_store;
      end
      S_DELAY: begin
        ctl.load_delay = 1'b1;
      end
      S_DRAIN_PUSH, S_DRAIN_WAIT, S_DRAIN_END, S_DELAY_OUT: begin
        ctl = '0;
      end
    endcase
  end

endmodule

/* rtl/rwc_datapath.sv */
// Datapath of the register write coalescer: burst state, byte store and output register.
// Depends on rwc_pkg.
module rwc_datapath #(
  parameter int BUFFER_DEPTH = rwc_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rwc_pkg::in_item_t   in_item,
  input  rwc_pkg::ctl_cmd_t   ctl,
  output rwc_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_stall,
  output rwc_pkg::out_item_t  out_item
);
  import rwc_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FW = $clog2(BUFFER_DEPTH + 1);

  // Latched input item.
  cmd_t        pend_cmd_r;
  logic [15:0] pend_addr_r;
  logic [7:0]  pend_val_r;

  logic          open_r, open_nxt;
  logic [15:0]   base_r, base_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          kind_r, kind_nxt;
  logic          drain_more_r, drain_more_nxt;
  logic [7:0]    rd_data_r;

  logic [7:0]    mem [BUFFER_DEPTH];

  logic [FW-1:0] eff_fill;
  logic [AW-1:0] wr_idx;
  logic          out_fire;
  logic          at_last;
  logic          drain_done;

  assign eff_fill   = open_r ? fill_r : '0;
  assign wr_idx     = eff_fill[AW-1:0];
  assign out_fire   = out_valid_r && !out_stall;
  assign at_last    = (FW'(rd_ptr_r) + FW'(1)) == fill_r;
  assign drain_done = out_fire && (kind_r == KIND_DATA) && at_last;

  always_comb begin
    status.pend_cmd         = pend_cmd_r;
    status.burst_open       = open_r;
    // Continuation is tested on the full 17-bit sum, so no wrap at the top.
    status.contiguous       = ({1'b0, base_r} + 17'(fill_r)) == {1'b0, pend_addr_r};
    status.full_after_store = (eff_fill + FW'(1)) == FW'(BUFFER_DEPTH);
    status.drain_done       = drain_done;
    status.delay_done       = out_fire && (kind_r == KIND_DELAY);
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      pend_cmd_r  <= in_item.cmd;
      pend_addr_r <= in_item.reg_addr;
      pend_val_r  <= in_item.value;
    end
  end

  always_comb begin
    open_nxt       = open_r;
    base_nxt       = base_r;
    fill_nxt       = fill_r;
    rd_ptr_nxt     = rd_ptr_r;
    out_valid_nxt  = out_valid_r;
    kind_nxt       = kind_r;
    drain_more_nxt = drain_more_r;

    if (ctl.store) begin
      open_nxt = 1'b1;
      fill_nxt = eff_fill + FW'(1);
      if (!open_r) base_nxt = pend_addr_r;
    end
    if (ctl.close) begin
      open_nxt = 1'b0;
      fill_nxt = '0;
    end
    if (out_fire) begin
      if (kind_r == KIND_DELAY) begin
        out_valid_nxt = 1'b0;
      end else if (at_last) begin
        out_valid_nxt = 1'b0;
        open_nxt      = 1'b0;
        fill_nxt      = '0;
      end else begin
        rd_ptr_nxt = rd_ptr_r + AW'(1);
      end
    end
    if (ctl.start_drain) begin
      rd_ptr_nxt     = '0;
      out_valid_nxt  = 1'b1;
      kind_nxt       = KIND_DATA;
      drain_more_nxt = ctl.drain_more;
    end
    if (ctl.load_delay) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_DELAY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r       <= 1'b0;
      base_r       <= '0;
      fill_r       <= '0;
      rd_ptr_r     <= '0;
      out_valid_r  <= 1'b0;
      kind_r       <= KIND_DATA;
      drain_more_r <= 1'b0;
    end else begin
      open_r       <= open_nxt;
      base_r       <= base_nxt;
      fill_r       <= fill_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      out_valid_r  <= out_valid_nxt;
      kind_r       <= kind_nxt;
      drain_more_r <= drain_more_nxt;
    end
  end

  // Byte store. The read data always tracks the entry at rd_ptr_r; a write to
  // that same entry is forwarded so a one-byte burst drains correctly.
  always_ff @(posedge clk) begin
    if (ctl.store) mem[wr_idx] <= pend_val_r;
    if (ctl.store && (wr_idx == rd_ptr_nxt)) rd_data_r <= pend_val_r;
    else rd_data_r <= mem[rd_ptr_nxt];
  end

  assign out_valid           = out_valid_r;
  assign out_item.kind       = kind_r;
  assign out_item.burst_base = (kind_r == KIND_DELAY) ? 16'd0 : base_r;
  assign out_item.payload    = (kind_r == KIND_DELAY) ? pend_val_r : rd_data_r;
  assign out_item.last       = (kind_r == KIND_DELAY) || (at_last && !drain_more_r);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for register_write_coalescer_top. It drives pushes, waits,
// flushes and discards, and checks every bus item against an in-bench burst predictor.
// Depends on rwc_pkg and register_write_coalescer_top.
module tb_top;
  import rwc_pkg::*;

  localparam int BUFFER_DEPTH = BUFFER_DEPTH_DEF;
  // Cycles to keep watching after the last expected item has come out.
  localparam int DRAIN_SETTLE = 40;
  // Upper bound on how long one drain may take before leftovers count as failures.
  localparam int DRAIN_LIMIT  = 20000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int LONG_HOLD    = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  register_write_coalescer_top #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Predictor state: the open burst as the block should hold it.
  logic        burst_open_m = 1'b0;
  logic [15:0] burst_base_m = '0;
  int          burst_fill_m = 0;
  logic [7:0]  burst_bytes_m [BUFFER_DEPTH];

  // Items caused by the input currently being predicted, then all items still due.
  out_item_t   step_items[$];
  out_item_t   pending_bus_items[$];

  int          error_count = 0;
  // Random idling on the sender and receiver side, switched per test phase.
  bit          tx_idle_en  = 1'b1;
  bit          rx_idle_en  = 1'b1;
  // Set by a test to make the receiver hold off for this many cycles.
  int          hold_cycles = 0;

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // A fixed ceiling on the run. The slowest legal run stays far below it.
  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= 50) begin
      $display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Burst predictor
  // ---------------------------------------------------------------------------

  function automatic void add_step_item(logic kind, logic [15:0] base, logic [7:0] data);
    out_item_t r;
    r.kind       = kind;
    r.burst_base = base;
    r.payload    = data;
    r.last       = 1'b0;
    step_items.push_back(r);
  endfunction

  function automatic void close_open_burst();
    burst_open_m = 1'b0;
    burst_base_m = '0;
    burst_fill_m = 0;
  endfunction

  // Sends the stored bytes of the open burst, oldest first, then closes it.
  function automatic void emit_open_burst();
    int i;
    if (burst_open_m) begin
      for (i = 0; i < burst_fill_m; i++) begin
        add_step_item(KIND_DATA, burst_base_m, burst_bytes_m[i]);
      end
    end
    close_open_burst();
  endfunction

  // Works out the bus items that one accepted register write command causes
  // and appends them to the pending list, with last on the final one.
  function automatic void coalesce_write(in_item_t it);
    int        i;
    out_item_t r;
    step_items.delete();
    case (it.cmd)
      CMD_PUSH: begin
        // Continuation is tested on the full sum, so a burst that ends at the
        // top of the address space never continues at address zero.
        if (burst_open_m && (int'(burst_base_m) + burst_fill_m) != int'(it.reg_addr)) begin
          emit_open_burst();
        end
        if (!burst_open_m) begin
          burst_open_m = 1'b1;
          burst_base_m = it.reg_addr;
          burst_fill_m = 0;
        end
        if (burst_fill_m < BUFFER_DEPTH) begin
          burst_bytes_m[burst_fill_m] = it.value;
          burst_fill_m++;
        end
        if (burst_fill_m >= BUFFER_DEPTH) begin
          emit_open_burst();
        end
      end
      CMD_WAIT: begin
        emit_open_burst();
        add_step_item(KIND_DELAY, 16'h0000, it.value);
      end
      CMD_FLUSH: begin
        emit_open_burst();
      end
      default: begin
        close_open_burst();
      end
    endcase
    for (i = 0; i < step_items.size(); i++) begin
      r      = step_items[i];
      r.last = (i == step_items.size() - 1);
      pending_bus_items.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender, receiver and result checker
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_item(cmd_t c, logic [15:0] a, logic [7:0] v);
    in_item_t it;
    it.cmd      = c;
    it.reg_addr = a;
    it.value    = v;
    return it;
  endfunction

  // Offers one item and holds it until the block takes it. Valid stays high on
  // return so that back-to-back items need no drop in between; a random gap
  // lowers it first. The prediction is made at the edge that accepts the item.
  task automatic send_item(input in_item_t it);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    coalesce_write(it);
  endtask

  // Pauses the sender until every expected item has come out, then lets the
  // block settle. Anything still due after the limit is a failure.
  task automatic wait_until_drained();
    int waited;
    waited   = 0;
    in_valid <= 1'b0;
    while (pending_bus_items.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_SETTLE) @(posedge clk);
    if (pending_bus_items.size() != 0) begin
      report_mismatch("items never delivered", 0, pending_bus_items.size());
      pending_bus_items.delete();
    end
  endtask

  // Receiver stall. A requested long hold-off is counted down here; otherwise
  // the receiver stalls in random bursts of random length while idling is on.
  initial begin : rx_stall_gen
    int burst_left;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall  <= 1'b1;
        burst_left = $urandom_range(1, 12) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every item taken on the result side is compared with the oldest one due.
  // All values read here are those from just before the edge.
  always @(posedge clk) begin : result_check
    out_item_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bus_items.size() == 0) begin
        report_mismatch("unexpected item (payload)", out_item.payload, 0);
      end else begin
        due = pending_bus_items.pop_front();
        if (out_item.kind !== due.kind)
          report_mismatch("kind", out_item.kind, due.kind);
        if (out_item.burst_base !== due.burst_base)
          report_mismatch("burst_base", out_item.burst_base, due.burst_base);
        if (out_item.payload !== due.payload)
          report_mismatch("payload", out_item.payload, due.payload);
        if (out_item.last !== due.last)
          report_mismatch("last", out_item.last, due.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // With nothing buffered, flush and discard give nothing and wait gives the
  // delay item alone.
  task automatic test_empty_buffer();
    send_item(make_item(CMD_FLUSH, 16'h0000, 8'h00));
    send_item(make_item(CMD_WAIT, 16'hFFFF, 8'h00));
    send_item(make_item(CMD_DISCARD, 16'h5555, 8'hAA));
  endtask

  // Lowest address and both byte extremes in one two-byte burst.
  task automatic test_field_extremes();
    send_item(make_item(CMD_PUSH, 16'h0000, 8'h00));
    send_item(make_item(CMD_PUSH, 16'h0001, 8'hFF));
    send_item(make_item(CMD_FLUSH, 16'hFFFF, 8'h00));
  endtask

  // A burst ending at the top address must not continue at address zero; the
  // wait then sends the new burst followed by the largest delay.
  task automatic test_address_top();
    send_item(make_item(CMD_PUSH, 16'hFFFF, 8'hA5));
    send_item(make_item(CMD_PUSH, 16'h0000, 8'h5A));
    send_item(make_item(CMD_WAIT, 16'h1234, 8'hFF));
  endtask

  // Discarded bytes are never sent, and the flush after it finds nothing.
  task automatic test_discard();
    send_item(make_item(CMD_PUSH, 16'h4000, 8'h11));
    send_item(make_item(CMD_DISCARD, 16'h4001, 8'h22));
    send_item(make_item(CMD_FLUSH, 16'h4001, 8'h33));
  endtask

  // Sixteen contiguous bytes up to the top address: the last push fills the
  // buffer and sends the whole burst by itself.
  task automatic test_full_burst();
    int i;
    for (i = 0; i < BUFFER_DEPTH; i++) begin
      send_item(make_item(CMD_PUSH, 16'hFFFF - 16'(BUFFER_DEPTH - 1 - i), 8'($urandom)));
    end
  endtask

  // The receiver holds off for a long time while the sender keeps offering
  // pushes, so the block fills up and stalls its input side.
  task automatic test_backpressure();
    int          i;
    logic [15:0] addr;
    addr        = 16'($urandom);
    hold_cycles = LONG_HOLD;
    for (i = 0; i < BUFFER_DEPTH + 8; i++) begin
      send_item(make_item(CMD_PUSH, addr, 8'($urandom)));
      addr++;
    end
    send_item(make_item(CMD_WAIT, 16'($urandom), 8'($urandom)));
  endtask

  // Mostly runs of contiguous pushes with random content, sometimes broken by
  // a skipped address, each often closed by a wait, flush or discard. The rest
  // is fully random commands.
  task automatic test_random_traffic(input int item_budget);
    int          sent;
    int          run_len;
    int          i;
    logic [15:0] addr;
    sent = 0;
    while (sent < item_budget) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 4) == 0) begin
          addr = 16'hFFFF - 16'($urandom_range(0, 6));
        end else begin
          addr = 16'($urandom);
        end
        if ($urandom_range(0, 5) == 0) begin
          run_len = $urandom_range(1, BUFFER_DEPTH + 4);
        end else begin
          run_len = $urandom_range(1, 5);
        end
        for (i = 0; i < run_len; i++) begin
          send_item(make_item(CMD_PUSH, addr, 8'($urandom)));
          addr = addr + (($urandom_range(0, 9) == 0) ? 16'd2 : 16'd1);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          send_item(make_item(cmd_t'($urandom_range(1, 3)), 16'($urandom), 8'($urandom)));
          sent++;
        end
      end else begin
        send_item(make_item(cmd_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom)));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    // Synchronous reset held low first, then released for good.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_buffer();
    test_field_extremes();
    test_address_top();
    test_discard();
    test_full_burst();
    // The sender stops here until every item due so far has come out.
    wait_until_drained();

    test_backpressure();
    wait_until_drained();

    test_random_traffic(40);
    wait_until_drained();

    // Final stretch at full rate on both sides.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(15);
    wait_until_drained();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* register_write_coalescer_top.f */
rtl/rwc_pkg.sv
rtl/rwc_ctrl.sv
rtl/rwc_datapath.sv
rtl/register_write_coalescer_top.sv
tb/tb_top.sv
